// ===== hdl/gfq_pkg.sv =====
// shared types and codes for the grouped fifo queue
// used by gfq_ctrl, gfq_store and grouped_fifo_queue_unit; depends on nothing
`default_nettype none
package gfq_pkg;

   localparam int TAG_W      = 16;
   localparam int KEY_FIELD_W = 16;
   localparam int STATUS_W   = 2;

   localparam logic [STATUS_W-1:0] STATUS_ENQUEUED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DEQUEUED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd3;

   localparam logic MODE_ENQUEUE = 1'b0;
   localparam logic MODE_DEQUEUE = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SCAN
   } gfq_state_type;

   typedef struct packed {
      logic capture;
      logic dequeue;
      logic post_empty;
      logic post_full;
      logic scan;
   } gfq_cmd_type;

   typedef struct packed {
      logic is_dequeue;
      logic empty;
      logic full;
      logic insert_here;
   } gfq_stat_type;

endpackage
`default_nettype wire

// ===== hdl/gfq_ctrl.sv =====
// controller for the grouped fifo queue: sequences capture, decision and insert scan
// depends on gfq_pkg
`default_nettype none
module gfq_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire gfq_pkg::gfq_stat_type stat,
   output gfq_pkg::gfq_cmd_type      cmd
);
   import gfq_pkg::*;

   gfq_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          can_accept;
   logic          post;

   assign can_accept = (state_ff == ST_IDLE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && can_accept) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (stat.is_dequeue || stat.full) state_in = ST_IDLE;
            else                              state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (stat.insert_here) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_valid && can_accept;
         end
         ST_DECIDE: begin
            if (stat.is_dequeue) begin
               cmd.post_empty = stat.empty;
               cmd.dequeue    = !stat.empty;
            end else begin
               cmd.post_full = stat.full;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         default: cmd = '0;
      endcase
   end

   assign post = cmd.dequeue || cmd.post_empty || cmd.post_full ||
                 (cmd.scan && stat.insert_here);

   // output register holds until the receiver takes the transfer
   assign rsp_valid_in = post || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = !can_accept;
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== hdl/gfq_store.sv =====
// datapath for the grouped fifo queue: slot registers, match vector, fill count,
// insert scan counter and result payload register; depends on gfq_pkg
`default_nettype none
module gfq_store #(
   parameter int QUEUE_DEPTH = 16,
   parameter int KEY_BITS    = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_mode,
   input  wire logic [gfq_pkg::KEY_FIELD_W-1:0]    req_group_key,
   input  wire logic [gfq_pkg::TAG_W-1:0]          req_entry_tag,
   input  wire gfq_pkg::gfq_cmd_type               cmd,
   output gfq_pkg::gfq_stat_type                   stat,
   output logic [gfq_pkg::STATUS_W-1:0]            rsp_status,
   output logic [gfq_pkg::TAG_W-1:0]               rsp_out_tag
);
   import gfq_pkg::*;

   localparam int SK    = (KEY_BITS < KEY_FIELD_W) ? KEY_BITS : KEY_FIELD_W;
   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

   logic [SK-1:0]    slot_grp_ff [QUEUE_DEPTH];
   logic [TAG_W-1:0] slot_tag_ff [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] match_ff, match_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] cnt_m1;
   logic [SK-1:0]    key_ff;
   logic [TAG_W-1:0] tag_ff;
   logic             mode_ff;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [TAG_W-1:0] out_tag_ff, out_tag_in;
   logic             any_match;
   logic             insert_here;
   logic             do_step;
   logic             do_insert;

   // only occupied slots take part in the group compare
   always_comb begin
      for (int j = 0; j < QUEUE_DEPTH; j++) begin
         match_in[j] = (CNT_W'(j) < fill_ff) && (slot_grp_ff[j] == req_group_key[SK-1:0]);
      end
   end

   assign any_match   = |match_ff;
   assign cnt_m1      = cnt_ff - CNT_ONE;
   // insert point reached when the slot just ahead holds the last entry of the group, or at the tail if absent
   assign insert_here = !any_match || (cnt_ff == '0) || match_ff[cnt_m1[IDX_W-1:0]];
   assign do_step     = cmd.scan && !insert_here;
   assign do_insert   = cmd.scan && insert_here;

   always_comb begin
      fill_in = fill_ff;
      if (cmd.dequeue)   fill_in = fill_ff - CNT_ONE;
      else if (do_insert) fill_in = fill_ff + CNT_ONE;
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.capture)   cnt_in = fill_ff;
      else if (do_step)  cnt_in = cnt_m1;
   end

   always_comb begin
      status_in  = status_ff;
      out_tag_in = out_tag_ff;
      if (cmd.dequeue) begin
         status_in  = STATUS_DEQUEUED;
         out_tag_in = slot_tag_ff[0];
      end else if (cmd.post_empty) begin
         status_in  = STATUS_EMPTY;
         out_tag_in = '0;
      end else if (cmd.post_full) begin
         status_in  = STATUS_FULL;
         out_tag_in = '0;
      end else if (do_insert) begin
         status_in  = STATUS_ENQUEUED;
         out_tag_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      status_ff  <= status_in;
      out_tag_ff <= out_tag_in;
      if (cmd.capture) begin
         key_ff   <= req_group_key[SK-1:0];
         tag_ff   <= req_entry_tag;
         mode_ff  <= req_mode;
         match_ff <= match_in;
      end
   end

   // each slot loads a neighbour (forward on dequeue, back in the scan) or the new entry
   for (genvar j = 0; j < QUEUE_DEPTH; j++) begin : g_slot
      if (j == 0) begin : g_head
         always_ff @(posedge clock) begin
            if (cmd.dequeue) begin
               slot_grp_ff[j] <= slot_grp_ff[j+1];
               slot_tag_ff[j] <= slot_tag_ff[j+1];
            end else if (do_insert && cnt_ff == CNT_W'(j)) begin
               slot_grp_ff[j] <= key_ff;
               slot_tag_ff[j] <= tag_ff;
            end
         end
      end else if (j == QUEUE_DEPTH - 1) begin : g_last
         always_ff @(posedge clock) begin
            if (do_step && cnt_ff == CNT_W'(j)) begin
               slot_grp_ff[j] <= slot_grp_ff[j-1];
               slot_tag_ff[j] <= slot_tag_ff[j-1];
            end else if (do_insert && cnt_ff == CNT_W'(j)) begin
               slot_grp_ff[j] <= key_ff;
               slot_tag_ff[j] <= tag_ff;
            end
         end
      end else begin : g_mid
         always_ff @(posedge clock) begin
            if (cmd.dequeue) begin
               slot_grp_ff[j] <= slot_grp_ff[j+1];
               slot_tag_ff[j] <= slot_tag_ff[j+1];
            end else if (do_step && cnt_ff == CNT_W'(j)) begin
               slot_grp_ff[j] <= slot_grp_ff[j-1];
               slot_tag_ff[j] <= slot_tag_ff[j-1];
            end else if (do_insert && cnt_ff == CNT_W'(j)) begin
               slot_grp_ff[j] <= key_ff;
               slot_tag_ff[j] <= tag_ff;
            end
         end
      end
   end

   assign stat.is_dequeue  = (mode_ff == MODE_DEQUEUE);
   assign stat.empty       = (fill_ff == '0);
   assign stat.full        = (fill_ff == DEPTH_CNT);
   assign stat.insert_here = insert_here;

   assign rsp_status  = status_ff;
   assign rsp_out_tag = out_tag_ff;

endmodule
`default_nettype wire

// ===== hdl/grouped_fifo_queue_unit.sv =====
// top level of the grouped fifo queue: controller plus slot datapath
// depends on gfq_pkg, gfq_ctrl and gfq_store
//
// usage: the req channel carries one command per transfer: mode enqueue with a
// group key and tag, or mode dequeue. every request gives exactly one rsp
// transfer with a status code and, for a dequeue, the tag of the removed head.
// an enqueued entry lands directly behind the last queued entry of its group,
// or at the tail when the group is absent; a full queue drops it (status full).
// a dequeue, an empty report or a full report is settled in the decide state and
// posted through the output register. an enqueue also runs the insert scan over
// the entries behind its insert point, moving one slot per cycle.
// one request is in flight at a time; the next is taken once the result has
// been posted and the output register is free or being drained.
// a stalled rsp holds its payload and blocks new requests (req_stall high).
// reset empties the queue at once and drops any pending result; slot contents
// are not cleared, only the fill count.
`default_nettype none
module grouped_fifo_queue_unit #(
   parameter int QUEUE_DEPTH = 16,
   parameter int KEY_BITS    = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_mode,
   input  wire logic [gfq_pkg::KEY_FIELD_W-1:0] req_group_key,
   input  wire logic [gfq_pkg::TAG_W-1:0]       req_entry_tag,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [gfq_pkg::STATUS_W-1:0]         rsp_status,
   output logic [gfq_pkg::TAG_W-1:0]            rsp_out_tag
);
   import gfq_pkg::*;

   gfq_cmd_type  cmd;
   gfq_stat_type stat;

   gfq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   gfq_store #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .KEY_BITS    (KEY_BITS)
   ) u_store (
      .clock         (clock),
      .reset         (reset),
      .req_mode      (req_mode),
      .req_group_key (req_group_key),
      .req_entry_tag (req_entry_tag),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_status    (rsp_status),
      .rsp_out_tag   (rsp_out_tag)
   );

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// self-checking bench for grouped_fifo_queue_unit: directed and random request traffic
// keeps a shadow copy of the queue to work out each response, depends on gfq_pkg
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gfq_pkg::*;

   localparam int DEPTH       = 16;
   localparam int KEY_W       = 16;
   localparam int ITEM_TARGET = 1800;
   localparam int DRAIN_WAIT  = 2 * (DEPTH + 4);
   localparam logic [KEY_FIELD_W-1:0] KEY_MASK = KEY_FIELD_W'((64'd1 << KEY_W) - 1);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [TAG_W-1:0]    tag;
   } queue_result_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_mode = MODE_ENQUEUE;
   logic [KEY_FIELD_W-1:0] req_group_key = '0;
   logic [TAG_W-1:0]       req_entry_tag = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [STATUS_W-1:0]    rsp_status;
   logic [TAG_W-1:0]       rsp_out_tag;

   // shadow of the queue contents, head at index 0
   logic [KEY_FIELD_W-1:0] shadow_group [DEPTH];
   logic [TAG_W-1:0]       shadow_tag [DEPTH];
   int                     shadow_fill = 0;

   queue_result_type expected_results [$];
   int               mismatch_count = 0;
   int               requests_sent = 0;
   logic             no_idle = 1'b0;

   grouped_fifo_queue_unit #(
      .QUEUE_DEPTH(DEPTH),
      .KEY_BITS   (KEY_W)
   ) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_mode     (req_mode),
      .req_group_key(req_group_key),
      .req_entry_tag(req_entry_tag),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_out_tag  (rsp_out_tag)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_stall <= !no_idle && ($urandom_range(99) < 8);
   end

   // applies one request to the shadow queue and returns the response it gives
   function automatic queue_result_type apply_queue_op(logic mode,
                                                       logic [KEY_FIELD_W-1:0] key,
                                                       logic [TAG_W-1:0] tag);
      queue_result_type       res;
      logic [KEY_FIELD_W-1:0] k;
      int                     pos;
      res.status = STATUS_ENQUEUED;
      res.tag    = '0;
      k          = key & KEY_MASK;
      if (mode == MODE_DEQUEUE) begin
         if (shadow_fill == 0) begin
            res.status = STATUS_EMPTY;
         end else begin
            res.status = STATUS_DEQUEUED;
            res.tag    = shadow_tag[0];
            for (int i = 1; i < shadow_fill; i++) begin
               shadow_group[i-1] = shadow_group[i];
               shadow_tag[i-1]   = shadow_tag[i];
            end
            shadow_fill--;
         end
      end else if (shadow_fill >= DEPTH) begin
         res.status = STATUS_FULL;
      end else begin
         // land behind the last entry of the same group, else at the tail
         pos = shadow_fill;
         for (int i = 0; i < shadow_fill; i++) begin
            if (shadow_group[i] == k) pos = i + 1;
         end
         for (int i = shadow_fill; i > pos; i--) begin
            shadow_group[i] = shadow_group[i-1];
            shadow_tag[i]   = shadow_tag[i-1];
         end
         shadow_group[pos] = k;
         shadow_tag[pos]   = tag;
         shadow_fill++;
      end
      return res;
   endfunction

   task automatic send_request(logic mode, logic [KEY_FIELD_W-1:0] key, logic [TAG_W-1:0] tag);
      @(negedge clock);
      if (!no_idle) begin
         while ($urandom_range(99) < 8) begin
            req_valid = 1'b0;
            @(negedge clock);
         end
      end
      req_valid     = 1'b1;
      req_mode      = mode;
      req_group_key = key;
      req_entry_tag = tag;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_results.push_back(apply_queue_op(mode, key, tag));
      requests_sent++;
   endtask

   task automatic report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch at %0t: %s", $realtime, what);
   endtask

   always @(posedge clock) begin : check_rsp
      queue_result_type exp_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            report_mismatch($sformatf("unexpected response status %0d tag %h",
                                      rsp_status, rsp_out_tag));
         end else begin
            exp_res = expected_results.pop_front();
            if (rsp_status !== exp_res.status || rsp_out_tag !== exp_res.tag)
               report_mismatch($sformatf("status exp %0d got %0d, tag exp %h got %h",
                                         exp_res.status, rsp_status, exp_res.tag,
                                         rsp_out_tag));
         end
      end
   end

   task automatic test_empty_and_extremes();
      send_request(MODE_DEQUEUE, 16'hFFFF, 16'hFFFF);
      send_request(MODE_DEQUEUE, 16'h0000, 16'h0000);
      // key zero is an ordinary group
      send_request(MODE_ENQUEUE, 16'h0000, 16'hFFFF);
      send_request(MODE_ENQUEUE, 16'hFFFF, 16'h0000);
      send_request(MODE_ENQUEUE, 16'h0000, 16'h0001);
      repeat (4) send_request(MODE_DEQUEUE, 16'h0000, 16'h0000);
   endtask

   task automatic test_group_insert();
      send_request(MODE_ENQUEUE, 16'hAAAA, 16'h0011);
      send_request(MODE_ENQUEUE, 16'h5555, 16'h0022);
      send_request(MODE_ENQUEUE, 16'h1234, 16'h0033);
      // middle insert behind the first group
      send_request(MODE_ENQUEUE, 16'hAAAA, 16'h0044);
      // last entry of this group is the tail
      send_request(MODE_ENQUEUE, 16'h1234, 16'h0055);
      send_request(MODE_ENQUEUE, 16'h5555, 16'h0066);
      send_request(MODE_ENQUEUE, 16'h8001, 16'h0077);
      repeat (8) send_request(MODE_DEQUEUE, 16'hFFFF, 16'hFFFF);
   endtask

   task automatic test_fill_and_overflow();
      logic [KEY_FIELD_W-1:0] keys [3];
      for (int i = 0; i < 3; i++) keys[i] = KEY_FIELD_W'($urandom);
      repeat (DEPTH) send_request(MODE_ENQUEUE, keys[$urandom_range(2)], TAG_W'($urandom));
      // full: both a present group and a fresh one are dropped
      send_request(MODE_ENQUEUE, keys[0], TAG_W'($urandom));
      send_request(MODE_ENQUEUE, ~keys[1], TAG_W'($urandom));
      send_request(MODE_ENQUEUE, keys[2], TAG_W'($urandom));
      repeat (DEPTH + 2) send_request(MODE_DEQUEUE, KEY_FIELD_W'($urandom), TAG_W'($urandom));
   endtask

   task automatic test_random_traffic();
      logic [KEY_FIELD_W-1:0] pool [6];
      logic [KEY_FIELD_W-1:0] key;
      int                     pool_n;
      int                     enq_pct;
      int                     phase_len;
      int                     phase;
      phase = 0;
      while (requests_sent < ITEM_TARGET) begin
         // a small pool of keys per phase so groups collide often
         pool_n = $urandom_range(1, 6);
         for (int i = 0; i < 6; i++) begin
            case ($urandom_range(7))
               0:       pool[i] = '0;
               1:       pool[i] = '1;
               default: pool[i] = KEY_FIELD_W'($urandom);
            endcase
         end
         case ($urandom_range(2))
            0:       enq_pct = 75;
            1:       enq_pct = 50;
            default: enq_pct = 30;
         endcase
         no_idle   = (phase == 6);
         phase_len = no_idle ? 300 : $urandom_range(20, 80);
         repeat (phase_len) begin
            if ($urandom_range(99) < enq_pct) begin
               key = ($urandom_range(9) == 0) ? KEY_FIELD_W'($urandom)
                                              : pool[$urandom_range(pool_n - 1)];
               send_request(MODE_ENQUEUE, key, TAG_W'($urandom));
            end else begin
               send_request(MODE_DEQUEUE, KEY_FIELD_W'($urandom), TAG_W'($urandom));
            end
         end
         phase++;
      end
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_empty_and_extremes();
      test_group_insert();
      test_fill_and_overflow();
      test_random_traffic();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #4ms;
      $display("TB_ERROR");
      $finish;
   end

endmodule
